// ===== rtl/core/skct_pkg.sv =====
package skct_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int HANDLE_BITS_DEF = 16;

    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_DUP      = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  key;
        logic [15:0] child_in;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [15:0] child_out;
        logic [1:0]  status;
        logic [4:0]  entry_count;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic compare;
        logic execute;
    } ctl_t;

endpackage

// ===== rtl/core/skct_ctrl.sv =====
module skct_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output skct_pkg::ctl_t ctl
);
    import skct_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:   state_next = S_EXEC;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign ctl.capture = start && (state_reg == S_IDLE);
    assign ctl.compare = (state_reg == S_CMP);
    assign ctl.execute = (state_reg == S_EXEC);

endmodule

// ===== rtl/core/skct_dp.sv =====
module skct_dp #(
    parameter int DEPTH       = skct_pkg::DEPTH_DEF,
    parameter int HANDLE_BITS = skct_pkg::HANDLE_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  skct_pkg::ctl_t ctl,
    input  skct_pkg::req_t req,
    output logic           done,
    output skct_pkg::rsp_t rsp
);
    import skct_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    req_t                   req_reg;
    logic [7:0]             key_reg [DEPTH];
    logic [HANDLE_BITS-1:0] hdl_reg [DEPTH];
    logic [7:0]             key_next [DEPTH];
    logic [HANDLE_BITS-1:0] hdl_next [DEPTH];
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [DEPTH-1:0]       lt_reg;
    logic [DEPTH-1:0]       eq_reg;
    logic                   done_reg;
    rsp_t                   rsp_reg;
    rsp_t                   rsp_next;

    logic [63:0]            child_wide;
    logic [HANDLE_BITS-1:0] child_h;
    logic [HANDLE_BITS-1:0] found_h;
    logic [63:0]            found_wide;
    logic [31:0]            count_wide;
    logic                   found;
    logic                   is_ins;
    logic                   is_rem;
    logic                   ins_ok;
    logic                   rem_ok;

    assign child_wide = 64'(req_reg.child_in);
    assign child_h    = child_wide[HANDLE_BITS-1:0];

    always_comb
    begin
        found_h = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            found_h = found_h | (hdl_reg[i] & {HANDLE_BITS{eq_reg[i]}});
        end
    end

    assign found  = |eq_reg;
    assign is_ins = (req_reg.func == FUNC_INSERT);
    assign is_rem = (req_reg.func == FUNC_REMOVE);
    assign ins_ok = is_ins && !found && (count_reg < CW'(DEPTH));
    assign rem_ok = is_rem && found;

    // each cell keeps, takes the new pair, or takes a neighbor
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic below_lt;
        logic [7:0]             up_key;
        logic [HANDLE_BITS-1:0] up_hdl;
        logic [7:0]             dn_key;
        logic [HANDLE_BITS-1:0] dn_hdl;

        if (g == 0)
        begin : g_first
            assign below_lt = 1'b1;
            assign dn_key   = '0;
            assign dn_hdl   = '0;
        end
        else
        begin : g_rest
            assign below_lt = lt_reg[g-1];
            assign dn_key   = key_reg[g-1];
            assign dn_hdl   = hdl_reg[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_top
            assign up_key = '0;
            assign up_hdl = '0;
        end
        else
        begin : g_mid
            assign up_key = key_reg[g+1];
            assign up_hdl = hdl_reg[g+1];
        end

        always_comb
        begin
            key_next[g] = key_reg[g];
            hdl_next[g] = hdl_reg[g];
            if (ins_ok && !lt_reg[g])
            begin
                if (below_lt)
                begin
                    key_next[g] = req_reg.key;
                    hdl_next[g] = child_h;
                end
                else
                begin
                    key_next[g] = dn_key;
                    hdl_next[g] = dn_hdl;
                end
            end
            else if (rem_ok && !lt_reg[g])
            begin
                key_next[g] = up_key;
                hdl_next[g] = up_hdl;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (rem_ok)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign found_wide = 64'(found_h);
    assign count_wide = 32'(count_next);

    always_comb
    begin
        rsp_next.hit         = found;
        rsp_next.child_out   = found_wide[15:0];
        rsp_next.entry_count = count_wide[4:0];
        rsp_next.status      = ST_OK;
        if (is_ins)
        begin
            if (found)
            begin
                rsp_next.status = ST_DUP;
            end
            else if (!ins_ok)
            begin
                rsp_next.status = ST_FULL;
            end
        end
        else if (is_rem && !found)
        begin
            rsp_next.status = ST_NOTFOUND;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            req_reg <= req;
        end
        if (ctl.execute)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= '0;
            eq_reg <= '0;
        end
        else if (ctl.compare)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                lt_reg[i] <= (CW'(i) < count_reg) && (key_reg[i] < req_reg.key);
                eq_reg[i] <= (CW'(i) < count_reg) && (key_reg[i] == req_reg.key);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i < DEPTH; i++)
            begin
                key_reg[i] <= '0;
                hdl_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= ctl.execute;
            if (ctl.execute)
            begin
                count_reg <= count_next;
                for (int i = 0; i < DEPTH; i++)
                begin
                    key_reg[i] <= key_next[i];
                    hdl_reg[i] <= hdl_next[i];
                end
            end
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== rtl/core/sorted_key_child_table.sv =====
// Steps: an accepted item is captured, then the parallel key compare in every
// cell is registered, then the cell row is shifted/updated and the result is
// registered; done then strobes, and the result is taken while done is high, when
// the next item can already be accepted. busy is high in between.
// Reset (rst_n low, asynchronous) empties the table and clears all cells.
// Results are shown for one cycle; the receiver cannot stall them.
module sorted_key_child_table #(
    parameter int DEPTH       = skct_pkg::DEPTH_DEF,
    parameter int HANDLE_BITS = skct_pkg::HANDLE_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  skct_pkg::req_t req,
    output logic           done,
    output skct_pkg::rsp_t rsp
);
    import skct_pkg::*;

    ctl_t ctl;

    skct_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctl   (ctl)
    );

    skct_dp #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result missing three cycles after accept");

    a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == ST_FULL) |-> !rsp.hit)
        else $error("full status reported for a present key");

endmodule

// ===== dv/sorted_key_child_table_test.sv =====
module sorted_key_child_table_test;
    import skct_pkg::*;

    localparam logic [1:0] FUNC_SPARE = 2'd3;
    localparam int SLOTS        = DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 425;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    req_t req;
    rsp_t rsp;

    logic [7:0]  key_tab [SLOTS];
    logic [15:0] handle_tab [SLOTS];
    int          entries;
    rsp_t        pending_rsp [$];
    int          fail_count;
    int          idle_pct;
    int          cycle_count;

    sorted_key_child_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Node table model: applies one item, returns the result it should produce.
    function automatic rsp_t table_apply(req_t r);
        int          pos;
        int          i;
        logic        hit_now;
        logic [15:0] old_handle;
        logic [1:0]  st;
        rsp_t        o;
        pos = 0;
        while (pos < entries && key_tab[pos] < r.key)
            pos++;
        hit_now = (pos < entries) && (key_tab[pos] == r.key);
        old_handle = hit_now ? handle_tab[pos] : 16'h0000;
        st = ST_OK;
        if (r.func == FUNC_INSERT)
        begin
            if (hit_now)
                st = ST_DUP;
            else if (entries >= SLOTS)
                st = ST_FULL;
            else
            begin
                for (i = entries; i > pos; i--)
                begin
                    key_tab[i]    = key_tab[i - 1];
                    handle_tab[i] = handle_tab[i - 1];
                end
                key_tab[pos]    = r.key;
                handle_tab[pos] = r.child_in;
                entries++;
            end
        end
        else if (r.func == FUNC_REMOVE)
        begin
            if (!hit_now)
                st = ST_NOTFOUND;
            else
            begin
                for (i = pos; i + 1 < entries; i++)
                begin
                    key_tab[i]    = key_tab[i + 1];
                    handle_tab[i] = handle_tab[i + 1];
                end
                key_tab[entries - 1]    = 8'h00;
                handle_tab[entries - 1] = 16'h0000;
                entries--;
            end
        end
        o.hit         = hit_now;
        o.child_out   = old_handle;
        o.status      = st;
        o.entry_count = 5'(entries);
        return o;
    endfunction

    function automatic req_t make_req(logic [1:0] f, logic [7:0] k, logic [15:0] c);
        req_t r;
        r.func     = f;
        r.key      = k;
        r.child_in = c;
        return r;
    endfunction

    // Keys mostly from a small pool so hits, duplicates and a full table are common.
    function automatic req_t random_req(int ins_pct);
        int          roll;
        logic [1:0]  f;
        logic [7:0]  k;
        roll = $urandom_range(99);
        if (roll < ins_pct)
            f = FUNC_INSERT;
        else if (roll < ins_pct + 30)
            f = FUNC_REMOVE;
        else if (roll < 95)
            f = FUNC_LOOKUP;
        else
            f = FUNC_SPARE;
        if ($urandom_range(99) < 70)
            k = 8'($urandom_range(23) * 11);
        else
            k = 8'($urandom);
        return make_req(f, k, 16'($urandom));
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rsp_t exp_rsp;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $error("result with no item outstanding");
                    fail_count++;
                end
                else
                begin
                    exp_rsp = pending_rsp.pop_front();
                    if (rsp.hit !== exp_rsp.hit)
                    begin
                        $error("hit: expected %0d, got %0d", exp_rsp.hit, rsp.hit);
                        fail_count++;
                    end
                    if (rsp.child_out !== exp_rsp.child_out)
                    begin
                        $error("child_out: expected %0h, got %0h",
                               exp_rsp.child_out, rsp.child_out);
                        fail_count++;
                    end
                    if (rsp.status !== exp_rsp.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
                        fail_count++;
                    end
                    if (rsp.entry_count !== exp_rsp.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               exp_rsp.entry_count, rsp.entry_count);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                pending_rsp.push_back(table_apply(req));
        end
    end

    // start stays high after an item is taken; wait_quiet, or a next call that idles first, lowers it.
    task automatic send_item(input req_t r);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        req   <= r;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
    endtask

    task automatic wait_quiet;
        @(negedge clk);
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty;
        send_item(make_req(FUNC_LOOKUP, 8'h00, 16'hFFFF));
        send_item(make_req(FUNC_REMOVE, 8'h00, 16'h0000));
        send_item(make_req(FUNC_REMOVE, 8'hFF, 16'hFFFF));
        send_item(make_req(FUNC_SPARE, 8'hFF, 16'h5A5A));
    endtask

    task automatic test_basic;
        send_item(make_req(FUNC_INSERT, 8'hFF, 16'hFFFF));
        send_item(make_req(FUNC_INSERT, 8'h00, 16'h0000));
        send_item(make_req(FUNC_INSERT, 8'h80, 16'hAAAA));
        send_item(make_req(FUNC_INSERT, 8'h7F, 16'h5555));
        send_item(make_req(FUNC_INSERT, 8'hFF, 16'h1234));
        send_item(make_req(FUNC_LOOKUP, 8'h00, 16'hFFFF));
        send_item(make_req(FUNC_LOOKUP, 8'hFF, 16'h0000));
        send_item(make_req(FUNC_LOOKUP, 8'h81, 16'h0000));
        send_item(make_req(FUNC_SPARE, 8'h7F, 16'hFFFF));
        send_item(make_req(FUNC_REMOVE, 8'h80, 16'h0000));
        send_item(make_req(FUNC_REMOVE, 8'h80, 16'hFFFF));
        send_item(make_req(FUNC_LOOKUP, 8'h7F, 16'h0000));
    endtask

    task automatic test_full;
        int i;
        wait_quiet;
        while (entries > 0)
        begin
            send_item(make_req(FUNC_REMOVE, key_tab[0], 16'($urandom)));
            wait_quiet;
        end
        for (i = 0; i < SLOTS; i++)
            send_item(make_req(FUNC_INSERT, 8'(i * 17), 16'($urandom)));
        send_item(make_req(FUNC_INSERT, 8'h08, 16'hBEEF));
        send_item(make_req(FUNC_INSERT, 8'h11, 16'hFFFF));
        send_item(make_req(FUNC_LOOKUP, 8'hFF, 16'h0000));
        send_item(make_req(FUNC_REMOVE, 8'h00, 16'h0000));
        send_item(make_req(FUNC_INSERT, 8'h08, 16'hBEEF));
        send_item(make_req(FUNC_LOOKUP, 8'h08, 16'h0000));
        wait_quiet;
    endtask

    task automatic test_random;
        int pct_list [4];
        int ins_list [4];
        int p;
        pct_list = '{0, 54, 0, 27};
        ins_list = '{45, 35, 25, 40};
        for (p = 0; p < 4; p++)
        begin
            idle_pct = pct_list[p];
            repeat (PHASE_ITEMS)
                send_item(random_req(ins_list[p]));
        end
        idle_pct = 0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        idle_pct    = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty;
        test_basic;
        test_full;
        test_random;

        wait_quiet;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_rsp.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
